@@ rtl/core/rts_pkg.sv @@
// Shared constants and types of the record time sorter.
`timescale 1ns / 1ps

package rts_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int ARRIVAL_W   = 6;
    localparam int TIME_W      = 32;
    localparam int SUB_W       = 16;
    localparam int KEY_W       = 46;
    localparam int KEY_SCALE   = 10000;
    localparam int QUEUE_DEPTH = 2;

    // One request passed from the front part to the back part.
    typedef struct packed {
        logic [TIME_W-1:0] rec_time;
        logic [SUB_W-1:0]  sub;
        logic [KEY_W-1:0]  key;
        logic              write;
        logic              last;
        logic              unsorted;
        logic              overflow;
        logic              reorder;
    } item_t;

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SUB_W-1:0]  sub;
        logic [TIME_W-1:0] rec_time;
    } rec_t;

    // One result request.
    typedef struct packed {
        logic [TIME_W-1:0]    rec_time;
        logic [SUB_W-1:0]     sub;
        logic [ARRIVAL_W-1:0] idx;
        logic                 unsorted;
        logic                 overflow;
        logic                 last;
    } result_t;

endpackage

@@ rtl/core/rts_front.sv @@
// Front part: accepts records, runs the monotonic time check and builds the sort key.
`timescale 1ns / 1ps

module rts_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [rts_pkg::TIME_W-1:0]    record_time,
    input  logic [rts_pkg::SUB_W-1:0]     sub_counter,
    input  logic                          last_record,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output rts_pkg::item_t                q_item
);

    logic                          correct_enable_reg;
    logic [rts_pkg::CNT_W-1:0]     count_reg;
    logic [rts_pkg::TIME_W-1:0]    prev_time_reg;
    logic                          unsorted_reg;
    logic                          overflow_reg;

    logic                          accept;
    logic                          store;
    logic                          unsorted_next;
    logic                          overflow_next;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;
    assign store  = count_reg < rts_pkg::CNT_W'(rts_pkg::MAX_RECORDS);

    always_comb
    begin
        unsorted_next = unsorted_reg;
        overflow_next = overflow_reg;
        if (store)
        begin
            if (count_reg != '0 && record_time != '0 && prev_time_reg > record_time)
            begin
                unsorted_next = 1'b1;
            end
        end
        else
        begin
            overflow_next = 1'b1;
        end
    end

    always_comb
    begin
        q_item.rec_time = record_time;
        q_item.sub      = sub_counter;
        q_item.key      = rts_pkg::KEY_W'(record_time) * rts_pkg::KEY_W'(rts_pkg::KEY_SCALE)
                          + rts_pkg::KEY_W'(sub_counter);
        q_item.write    = store;
        q_item.last     = last_record;
        q_item.unsorted = unsorted_next;
        q_item.overflow = overflow_next;
        q_item.reorder  = unsorted_next && correct_enable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            correct_enable_reg <= 1'b1;
            count_reg          <= '0;
            prev_time_reg      <= '0;
            unsorted_reg       <= 1'b0;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                correct_enable_reg <= cfg_data;
            end
            if (accept)
            begin
                if (last_record)
                begin
                    count_reg     <= '0;
                    prev_time_reg <= '0;
                    unsorted_reg  <= 1'b0;
                    overflow_reg  <= 1'b0;
                end
                else
                begin
                    unsorted_reg <= unsorted_next;
                    overflow_reg <= overflow_next;
                    if (store)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (count_reg == '0 || record_time != '0)
                        begin
                            prev_time_reg <= record_time;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ rtl/core/rts_queue.sv @@
// Short queue between the front and back parts.
`timescale 1ns / 1ps

module rts_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rts_pkg::item_t  item_in,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output rts_pkg::item_t  item_out
);

    localparam int PTR_W = $clog2(rts_pkg::QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(rts_pkg::QUEUE_DEPTH + 1);

    rts_pkg::item_t      slot_reg [rts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;

    logic                do_push;
    logic                do_pop;

    assign full     = fill_reg == QCNT_W'(rts_pkg::QUEUE_DEPTH);
    assign valid    = fill_reg != '0;
    assign item_out = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/rts_back.sv @@
// Back part: record store, selection scan and result register.
`timescale 1ns / 1ps

module rts_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rts_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output rts_pkg::result_t   result
);

    typedef enum logic [1:0] {S_LOAD, S_SCAN, S_WAIT, S_PUT} state_t;

    state_t                          state_reg;
    rts_pkg::rec_t                   mem [rts_pkg::MAX_RECORDS];
    rts_pkg::rec_t                   rd_data_reg;
    logic                            rd_pend_reg;
    logic [rts_pkg::IDX_W-1:0]       rd_idx_reg;
    logic [rts_pkg::CNT_W-1:0]       count_reg;
    logic [rts_pkg::CNT_W-1:0]       n_reg;
    logic [rts_pkg::IDX_W-1:0]       pos_reg;
    logic [rts_pkg::IDX_W-1:0]       scan_reg;
    logic [rts_pkg::IDX_W-1:0]       end_reg;
    logic                            reorder_reg;
    logic                            unsorted_reg;
    logic                            overflow_reg;
    logic                            have_last_reg;
    logic [rts_pkg::KEY_W-1:0]       last_key_reg;
    logic [rts_pkg::IDX_W-1:0]       last_idx_reg;
    logic                            best_found_reg;
    logic [rts_pkg::KEY_W-1:0]       best_key_reg;
    logic [rts_pkg::IDX_W-1:0]       best_idx_reg;
    logic [rts_pkg::TIME_W-1:0]      best_time_reg;
    logic [rts_pkg::SUB_W-1:0]       best_sub_reg;
    logic                            out_valid_reg;
    rts_pkg::result_t                out_reg;

    logic                            wr_en;
    logic [rts_pkg::CNT_W-1:0]       n_cur;
    logic                            above;
    logic                            better;
    logic                            take;
    logic                            out_free;
    logic                            last_pos;

    assign q_pop    = state_reg == S_LOAD && q_valid;
    assign wr_en    = q_pop && q_item.write;
    assign n_cur    = count_reg + rts_pkg::CNT_W'(q_item.write);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign last_pos = rts_pkg::CNT_W'(pos_reg) + 1'b1 == n_reg;

    // next record above the last one emitted in (key, index) order
    assign above  = !have_last_reg || !reorder_reg
                    || rd_data_reg.key > last_key_reg
                    || (rd_data_reg.key == last_key_reg && rd_idx_reg > last_idx_reg);
    assign better = !best_found_reg || rd_data_reg.key < best_key_reg;
    assign take   = rd_pend_reg && above && better;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[rts_pkg::IDX_W-1:0]] <= '{key: q_item.key, sub: q_item.sub,
                                                   rec_time: q_item.rec_time};
        end
        rd_data_reg <= mem[scan_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            rd_pend_reg    <= 1'b0;
            count_reg      <= '0;
            n_reg          <= '0;
            pos_reg        <= '0;
            scan_reg       <= '0;
            end_reg        <= '0;
            reorder_reg    <= 1'b0;
            unsorted_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            have_last_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= 1'b0;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                best_found_reg <= 1'b1;
                best_key_reg   <= rd_data_reg.key;
                best_idx_reg   <= rd_idx_reg;
                best_time_reg  <= rd_data_reg.rec_time;
                best_sub_reg   <= rd_data_reg.sub;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        count_reg <= n_cur;
                        if (q_item.last)
                        begin
                            count_reg      <= '0;
                            n_reg          <= n_cur;
                            unsorted_reg   <= q_item.unsorted;
                            overflow_reg   <= q_item.overflow;
                            reorder_reg    <= q_item.reorder;
                            pos_reg        <= '0;
                            have_last_reg  <= 1'b0;
                            best_found_reg <= 1'b0;
                            scan_reg       <= '0;
                            end_reg        <= q_item.reorder
                                              ? rts_pkg::IDX_W'(n_cur - 1'b1) : '0;
                            state_reg      <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= scan_reg;
                    if (scan_reg == end_reg)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_PUT;
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_reg.rec_time <= best_time_reg;
                        out_reg.sub      <= best_sub_reg;
                        out_reg.idx      <= rts_pkg::ARRIVAL_W'(best_idx_reg);
                        out_reg.unsorted <= unsorted_reg;
                        out_reg.overflow <= overflow_reg;
                        out_reg.last     <= last_pos;
                        last_key_reg     <= best_key_reg;
                        last_idx_reg     <= best_idx_reg;
                        have_last_reg    <= 1'b1;
                        best_found_reg   <= 1'b0;
                        if (last_pos)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + 1'b1;
                            scan_reg  <= reorder_reg ? '0 : pos_reg + 1'b1;
                            end_reg   <= reorder_reg ? rts_pkg::IDX_W'(n_reg - 1'b1)
                                                     : pos_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_put_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUT |-> best_found_reg)
        else $error("no record selected for emission");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rts_pkg::CNT_W'(rts_pkg::MAX_RECORDS))
        else $error("store count beyond capacity");

    a_wait_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> rd_pend_reg)
        else $error("scan finished with no read in flight");

    a_scan_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> rts_pkg::CNT_W'(end_reg) < n_reg)
        else $error("scan beyond the loaded batch");

endmodule

@@ rtl/core/record_time_sorter.sv @@
// Top level of the record time sorter.
`timescale 1ns / 1ps
//
// Input queue: a record request is taken when push is high and full is low.
// Records load into a 64-entry store at one per cycle while no batch drains, until last_record.
// Nonzero times are checked for order; beyond 64 records are dropped and
// the batch is flagged as overflowed.
// Result register: while empty is low the result is on the ports and
// pop takes it. A batch gives one result per stored record, last_out on the last.
// Unsorted batches with cfg_data/cfg_write having set correction come out
// in ascending time*10000+sub_counter order, ties in arrival order; others
// in arrival order.
// Emission: after the last record each result takes one store scan (every
// stored record when reordering, a full scan of the store's single read
// port per result; only its own entry in arrival order), then the S_WAIT
// and S_PUT states.
// Records of the next batch wait in a two-entry queue while a batch drains.
// A stalled receiver holds the result register and pauses emission.
// Reset empties the queue and the result register and sets correction on.
//
module record_time_sorter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [rts_pkg::TIME_W-1:0]         record_time,
    input  logic [rts_pkg::SUB_W-1:0]          sub_counter,
    input  logic                               last_record,
    input  logic                               cfg_write,
    input  logic                               cfg_data,
    output logic                               empty,
    input  logic                               pop,
    output logic [rts_pkg::TIME_W-1:0]         out_time,
    output logic [rts_pkg::SUB_W-1:0]          out_sub_counter,
    output logic [rts_pkg::ARRIVAL_W-1:0]      arrival_index,
    output logic                               was_unsorted,
    output logic                               overflowed,
    output logic                               last_out
);

    logic               fq_push;
    logic               fq_full;
    rts_pkg::item_t     fq_item;
    logic               bq_valid;
    logic               bq_pop;
    rts_pkg::item_t     bq_item;
    rts_pkg::result_t   result;

    rts_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .record_time (record_time),
        .sub_counter (sub_counter),
        .last_record (last_record),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .q_full      (fq_full),
        .q_push      (fq_push),
        .q_item      (fq_item)
    );

    rts_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .item_in  (fq_item),
        .full     (fq_full),
        .pop      (bq_pop),
        .valid    (bq_valid),
        .item_out (bq_item)
    );

    rts_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (bq_valid),
        .q_item  (bq_item),
        .q_pop   (bq_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign out_time        = result.rec_time;
    assign out_sub_counter = result.sub;
    assign arrival_index   = result.idx;
    assign was_unsorted    = result.unsorted;
    assign overflowed      = result.overflow;
    assign last_out        = result.last;

endmodule

@@ tb/sv/tb_record_time_sorter.sv @@
// Self-checking testbench for the record time sorter: batch load, order check and key sort.
`timescale 1ns / 1ps

module tb_record_time_sorter;

    localparam int     CLK_HALF     = 5;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     MAX_GAP      = 5;
    localparam int     REPORT_LIMIT = 50;
    localparam longint TIMEOUT_NS   = 5_000_000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [rts_pkg::TIME_W-1:0]    record_time;
    logic [rts_pkg::SUB_W-1:0]     sub_counter;
    logic                          last_record;
    logic                          cfg_write;
    logic                          cfg_data;
    logic                          empty;
    logic                          pop;
    logic [rts_pkg::TIME_W-1:0]    out_time;
    logic [rts_pkg::SUB_W-1:0]     out_sub_counter;
    logic [rts_pkg::ARRIVAL_W-1:0] arrival_index;
    logic                          was_unsorted;
    logic                          overflowed;
    logic                          last_out;

    // predicted block state
    logic [rts_pkg::TIME_W-1:0] batch_time [rts_pkg::MAX_RECORDS];
    logic [rts_pkg::SUB_W-1:0]  batch_sub  [rts_pkg::MAX_RECORDS];
    int                         batch_count    = 0;
    logic [rts_pkg::TIME_W-1:0] newest_time    = '0;
    bit                         batch_unsorted = 1'b0;
    bit                         batch_overflow = 1'b0;
    bit                         correction_on  = 1'b1;

    rts_pkg::result_t           pending_results [$];
    int                         error_count = 0;
    bit                         tx_burst    = 1'b0;
    bit                         rx_burst    = 1'b0;

    record_time_sorter u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .record_time     (record_time),
        .sub_counter     (sub_counter),
        .last_record     (last_record),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .empty           (empty),
        .pop             (pop),
        .out_time        (out_time),
        .out_sub_counter (out_sub_counter),
        .arrival_index   (arrival_index),
        .was_unsorted    (was_unsorted),
        .overflowed      (overflowed),
        .last_out        (last_out)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        #TIMEOUT_NS;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_cycles(bit burst);
        if (burst)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [15:0] sub_value();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 3));
            1:       return 16'($urandom_range(9998, 10002));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int batch_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            return $urandom_range(1, 6);
        end
        if (sel < 90)
        begin
            return $urandom_range(7, 20);
        end
        if (sel < 97)
        begin
            return $urandom_range(21, 64);
        end
        return $urandom_range(65, 72);
    endfunction

    function automatic logic [63:0] sort_key(int slot);
        return {32'd0, batch_time[slot]} * 64'(rts_pkg::KEY_SCALE) + {48'd0, batch_sub[slot]};
    endfunction

    // Loads one accepted record; on the last one queues the whole batch in emission order.
    function automatic void load_record(logic [31:0] t, logic [15:0] s, logic is_last);
        int               order [rts_pkg::MAX_RECORDS];
        int               i;
        int               j;
        int               cur;
        rts_pkg::result_t r;
        if (batch_count < rts_pkg::MAX_RECORDS)
        begin
            if (batch_count == 0)
            begin
                newest_time = t;
            end
            else if (t != 0)
            begin
                if (newest_time > t)
                begin
                    batch_unsorted = 1'b1;
                end
                newest_time = t;
            end
            batch_time[batch_count] = t;
            batch_sub[batch_count]  = s;
            batch_count++;
        end
        else
        begin
            batch_overflow = 1'b1;
        end
        if (!is_last)
        begin
            return;
        end
        for (i = 0; i < batch_count; i++)
        begin
            order[i] = i;
        end
        // stable: equal keys stay in arrival order
        if (batch_unsorted && correction_on)
        begin
            for (i = 1; i < batch_count; i++)
            begin
                cur = order[i];
                j   = i;
                while (j > 0 && sort_key(order[j-1]) > sort_key(cur))
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
        end
        for (i = 0; i < batch_count; i++)
        begin
            r.rec_time = batch_time[order[i]];
            r.sub      = batch_sub[order[i]];
            r.idx      = 6'(order[i]);
            r.unsorted = batch_unsorted;
            r.overflow = batch_overflow;
            r.last     = (i == batch_count - 1);
            pending_results.push_back(r);
        end
        batch_count    = 0;
        newest_time    = '0;
        batch_unsorted = 1'b0;
        batch_overflow = 1'b0;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_record(logic [31:0] t, logic [15:0] s, logic is_last);
        int gap;
        gap = idle_cycles(tx_burst);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        record_time <= t;
        sub_counter <= s;
        last_record <= is_last;
        do
            @(posedge clk);
        while (full);
        load_record(t, s, is_last);
    endtask

    // Random batch: mostly non-decreasing times, some with descents, some fully random.
    task automatic send_batch(int n);
        int          style;
        int          k;
        logic [31:0] t;
        style = $urandom_range(0, 9);
        t     = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1000);
        for (k = 0; k < n; k++)
        begin
            if (style < 6)
            begin
                t = t + $urandom_range(0, 2);
            end
            else if (style < 9)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    t = t - $urandom_range(1, 3);
                end
                else
                begin
                    t = t + $urandom_range(0, 2);
                end
            end
            else
            begin
                t = $urandom;
            end
            send_record(($urandom_range(0, 7) == 0) ? 32'd0 : t, sub_value(), k == n - 1);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_correction(bit enable);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data  <= enable;
        @(posedge clk);
        cfg_write <= 1'b0;
        correction_on = enable;
    endtask

    task automatic check_result();
        rts_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with no request pending, time %h", out_time));
            return;
        end
        want = pending_results.pop_front();
        if (out_time !== want.rec_time)
        begin
            report_mismatch($sformatf("out_time %h, want %h", out_time, want.rec_time));
        end
        if (out_sub_counter !== want.sub)
        begin
            report_mismatch($sformatf("out_sub_counter %h, want %h", out_sub_counter, want.sub));
        end
        if (arrival_index !== want.idx)
        begin
            report_mismatch($sformatf("arrival_index %0d, want %0d", arrival_index, want.idx));
        end
        if (was_unsorted !== want.unsorted)
        begin
            report_mismatch($sformatf("was_unsorted %b, want %b", was_unsorted, want.unsorted));
        end
        if (overflowed !== want.overflow)
        begin
            report_mismatch($sformatf("overflowed %b, want %b", overflowed, want.overflow));
        end
        if (last_out !== want.last)
        begin
            report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
        end
    endtask

    initial
    begin : result_drain
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                rx_burst = !rx_burst;
            end
            gap = idle_cycles(rx_burst);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_result();
        end
    end

    task automatic test_single_record();
        set_correction(1'b1);
        send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_record(32'd0, 16'd0, 1'b1);
    endtask

    // zero times skip the order check but still sort with a time of zero in the key
    task automatic test_zero_time();
        send_record(32'd0, 16'd5, 1'b0);
        send_record(32'd7, 16'd1, 1'b0);
        send_record(32'd0, 16'd0, 1'b0);
        send_record(32'd3, 16'd2, 1'b1);
    endtask

    // sub-counters past the scale make keys of different times collide
    task automatic test_key_order();
        send_record(32'd2, 16'd0, 1'b0);
        send_record(32'd1, 16'd65535, 1'b0);
        send_record(32'd1, 16'd10000, 1'b0);
        send_record(32'd2, 16'd0, 1'b1);
    endtask

    task automatic test_key_extremes();
        send_record(32'hFFFF_FFFF, 16'h0000, 1'b0);
        send_record(32'hFFFF_FFFE, 16'hFFFF, 1'b0);
        send_record(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_record(32'h0000_0000, 16'hFFFF, 1'b1);
    endtask

    // equal times pass the check, so no reorder despite falling sub-counters
    task automatic test_in_order_ties();
        send_record(32'd4, 16'd3, 1'b0);
        send_record(32'd4, 16'd1, 1'b0);
        send_record(32'd4, 16'd2, 1'b1);
    endtask

    task automatic test_flag_only();
        set_correction(1'b0);
        send_record(32'd9, 16'd0, 1'b0);
        send_record(32'd8, 16'd0, 1'b0);
        send_record(32'd10, 16'd0, 1'b1);
    endtask

    task automatic test_overflow();
        int k;
        set_correction(1'b1);
        for (k = 0; k < rts_pkg::MAX_RECORDS; k++)
        begin
            send_record(32'(k + 1), sub_value(), k == rts_pkg::MAX_RECORDS - 1);
        end
        // one over: the request carrying last is itself dropped
        for (k = 0; k <= rts_pkg::MAX_RECORDS; k++)
        begin
            send_record(32'(rts_pkg::MAX_RECORDS - k), sub_value(), k == rts_pkg::MAX_RECORDS);
        end
        send_batch(rts_pkg::MAX_RECORDS + 6);
    endtask

    task automatic test_random(bit enable, int item_target);
        int sent;
        int n;
        set_correction(enable);
        sent = 0;
        while (sent < item_target)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            n        = batch_size();
            send_batch(n);
            sent += n;
        end
        tx_burst = 1'b0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        push        <= 1'b0;
        record_time <= '0;
        sub_counter <= '0;
        last_record <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_data    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_record();
        test_zero_time();
        test_key_order();
        test_key_extremes();
        test_in_order_ties();
        test_flag_only();
        test_overflow();
        test_random(1'b1, 60);
        test_random(1'b0, 50);
        test_random(1'b1, 50);

        wait_idle();
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
